/* design/fptp_pkg.sv */
// Package for the FSK pulse and tone packer: shared types, codes and constants.
// No dependencies; fptp_regs, fptp_dp, fptp_ctrl and the top level import it.
`default_nettype none

package fptp_pkg;

    // Fixed field widths.
    localparam int SPU_W      = 31;
    localparam int INC_W      = 32;
    localparam int FRAC_W     = 64;
    localparam int TOTAL_W    = 32;
    localparam int INDEX_W    = 27;
    localparam int BITCNT_W   = 6;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Samples appended for one pulse saturate here; 2048 samples give 64 words at most.
    localparam int MAX_PULSE_SAMPLES = 2048;
    localparam int CNT_W             = 12;
    localparam int WORD_BITS         = 32;

    // Register reset values.
    localparam logic [SPU_W-1:0] SPU_RESET   = 31'd1372671548;
    localparam logic [INC_W-1:0] MARK_RESET  = 32'd536870912;
    localparam logic [INC_W-1:0] SPACE_RESET = 32'd715827883;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_SPU   = 2'd0;
    localparam logic [1:0] REG_MARK  = 2'd1;
    localparam logic [1:0] REG_SPACE = 2'd2;

    // Opcodes of an input request.
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_CNT,
        S_CHK,
        S_ERR,
        S_FLUSH,
        S_RUN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic count;
        logic arm;
        logic step;
        logic emit_flush;
        logic emit_err;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic samples_zero;
        logic overflow;
        logic word_at_step;
        logic remain_one;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/fptp_req_if.sv */
// Input request channel of the packer: valid/ready handshake and pulse payload.
// Depends on no package.
`default_nettype none

interface fptp_req_if #(
    parameter int DW = 12
);
    logic          valid;
    logic          ready;
    logic          opcode;
    logic          pulse_polarity;
    logic [DW-1:0] duration_units;

    modport source (output valid, output opcode, output pulse_polarity,
                    output duration_units, input ready);
    modport sink   (input valid, input opcode, input pulse_polarity,
                    input duration_units, output ready);
endinterface

`default_nettype wire

/* design/fptp_rsp_if.sv */
// Result channel of the packer: valid/ready handshake and packed word payload.
// Depends on no package.
`default_nettype none

interface fptp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] fsk_word;
    logic [31:0] tone_word;
    logic [26:0] word_index;
    logic [5:0]  bit_count;
    logic        length_error;
    logic        last;

    modport source (output valid, output fsk_word, output tone_word, output word_index,
                    output bit_count, output length_error, output last, input ready);
    modport sink   (input valid, input fsk_word, input tone_word, input word_index,
                    input bit_count, input length_error, input last, output ready);
endinterface

`default_nettype wire

/* design/fptp_regs.sv */
// APB-style configuration registers: samples per unit and the two phase increments.
// Depends on fptp_pkg.
`default_nettype none

module fptp_regs
    import fptp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [SPU_W-1:0]  o_spu,
    output logic [INC_W-1:0]  o_mark_inc,
    output logic [INC_W-1:0]  o_space_inc
);

    logic [SPU_W-1:0] r_spu;
    logic [INC_W-1:0] r_mark;
    logic [INC_W-1:0] r_space;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu   <= SPU_RESET;
            r_mark  <= MARK_RESET;
            r_space <= SPACE_RESET;
        end else if (wr_en) begin
            if (reg_idx == REG_SPU) begin
                r_spu <= pwdata[SPU_W-1:0];
            end
            if (reg_idx == REG_MARK) begin
                r_mark <= pwdata;
            end
            if (reg_idx == REG_SPACE) begin
                r_space <= pwdata;
            end
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            REG_SPU:   prdata = {1'b0, r_spu};
            REG_MARK:  prdata = r_mark;
            REG_SPACE: prdata = r_space;
            default:   prdata = '0;
        endcase
    end

    assign o_spu       = r_spu;
    assign o_mark_inc  = r_mark;
    assign o_space_inc = r_space;

endmodule

`default_nettype wire

/* design/fptp_dp.sv */
// Datapath of the packer: duration multiply, carry update, phase accumulator,
// word packing and the result register. Depends on fptp_pkg.
`default_nettype none

module fptp_dp
    import fptp_pkg::*;
#(
    parameter int DURATION_BITS = 12
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_st,
    input  wire                      i_pulse_polarity,
    input  wire  [DURATION_BITS-1:0] i_duration_units,
    input  wire  [SPU_W-1:0]         i_spu,
    input  wire  [INC_W-1:0]         i_mark_inc,
    input  wire  [INC_W-1:0]         i_space_inc,
    input  wire                      i_out_ready,
    output logic                     o_out_valid,
    output logic [31:0]              o_fsk_word,
    output logic [31:0]              o_tone_word,
    output logic [INDEX_W-1:0]       o_word_index,
    output logic [BITCNT_W-1:0]      o_bit_count,
    output logic                     o_length_error,
    output logic                     o_last
);

    localparam int PROD_W = DURATION_BITS + SPU_W;

    // Item registers.
    logic                     r_pol;
    logic [DURATION_BITS-1:0] r_dur;
    logic [PROD_W-1:0]        r_prod;
    logic [FRAC_W-1:0]        r_f;
    logic [TOTAL_W-1:0]       r_samples;
    logic [INC_W-1:0]         r_inc;
    logic [CNT_W-1:0]         r_remain;

    // Persistent state.
    logic [FRAC_W-1:0]        r_carry;
    logic [INC_W-1:0]         r_phase;
    logic [TOTAL_W-1:0]       r_total;
    logic [31:0]              r_part_fsk;
    logic [31:0]              r_part_tone;

    // Result register.
    logic                     r_out_valid;
    logic [31:0]              r_out_fsk;
    logic [31:0]              r_out_tone;
    logic [INDEX_W-1:0]       r_out_index;
    logic [BITCNT_W-1:0]      r_out_count;
    logic                     r_out_err;
    logic                     r_out_last;

    logic [INC_W-1:0]         n_phase;
    logic [4:0]               offset;
    logic [4:0]               bit_pos;
    logic                     word_done;
    logic                     out_free;
    logic                     emit_word;

    assign n_phase   = r_phase + r_inc;
    assign offset    = r_total[4:0];
    assign bit_pos   = ~offset;
    assign word_done = &offset;
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_word = i_cmd.step && word_done;

    // Capture the request payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pol <= i_pulse_polarity;
            r_dur <= i_duration_units;
        end
    end

    // Duration times samples per unit, then the sample count from the 32.32 sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dur) * PROD_W'(i_spu);
        end
        if (i_cmd.add) begin
            r_f <= r_carry + FRAC_W'(r_prod);
        end
        if (i_cmd.count) begin
            // A negative sum yields no samples; otherwise round to nearest.
            r_samples <= r_f[FRAC_W-1] ? '0 : r_f[63:32] + TOTAL_W'(r_f[31]);
        end
        if (i_cmd.arm) begin
            r_inc <= r_pol ? i_mark_inc : i_space_inc;
        end
    end

    // Remaining samples of the current pulse, saturated at the pulse maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
        end else if (i_cmd.arm) begin
            r_remain <= (r_samples > TOTAL_W'(MAX_PULSE_SAMPLES)) ?
                        CNT_W'(MAX_PULSE_SAMPLES) : r_samples[CNT_W-1:0];
        end else if (i_cmd.step) begin
            r_remain <= r_remain - 1'b1;
        end
    end

    // Fractional carry: keep the residue after removing the whole samples; a negative sum is kept whole.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else if (i_cmd.count) begin
            if (r_f[FRAC_W-1]) begin
                r_carry <= r_f;
            end else begin
                r_carry <= {{32{r_f[31]}}, r_f[31:0]};
            end
        end
    end

    // One sample per step: phase accumulator and MSB-first packing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_total     <= '0;
            r_part_fsk  <= '0;
            r_part_tone <= '0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase;
            r_total <= r_total + 1'b1;
            if (word_done) begin
                r_part_fsk  <= '0;
                r_part_tone <= '0;
            end else begin
                r_part_fsk[bit_pos]  <= r_pol;
                r_part_tone[bit_pos] <= n_phase[31];
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_word || i_cmd.emit_flush || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: completed word, flushed partial word or length error.
    always_ff @(posedge i_clk) begin
        if (emit_word) begin
            r_out_fsk   <= {r_part_fsk[31:1], r_pol};
            r_out_tone  <= {r_part_tone[31:1], n_phase[31]};
            r_out_index <= r_total[TOTAL_W-1:5];
            r_out_count <= BITCNT_W'(WORD_BITS);
            r_out_err   <= 1'b0;
            r_out_last  <= (r_remain <= CNT_W'(WORD_BITS));
        end else if (i_cmd.emit_flush) begin
            r_out_fsk   <= r_part_fsk;
            r_out_tone  <= r_part_tone;
            r_out_index <= r_total[TOTAL_W-1:5];
            r_out_count <= BITCNT_W'(offset);
            r_out_err   <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit_err) begin
            r_out_fsk   <= '0;
            r_out_tone  <= '0;
            r_out_index <= '0;
            r_out_count <= '0;
            r_out_err   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fsk_word     = r_out_fsk;
    assign o_tone_word    = r_out_tone;
    assign o_word_index   = r_out_index;
    assign o_bit_count    = r_out_count;
    assign o_length_error = r_out_err;
    assign o_last         = r_out_last;

    // Status toward the controller.
    assign o_st.out_free     = out_free;
    assign o_st.samples_zero = (r_samples == '0);
    assign o_st.overflow     = (~r_total < r_samples);
    assign o_st.word_at_step = word_done;
    assign o_st.remain_one   = (r_remain == CNT_W'(1));

    // A completed word is only produced when the result register can take it.
    a_word_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_word |-> out_free)
        else $error("word completed while result register busy");

    // The per-pulse sample count never exceeds the saturation limit.
    a_remain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remain <= CNT_W'(MAX_PULSE_SAMPLES))
        else $error("remaining sample count out of range");

    // After a word completes the partial words start empty.
    a_part_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_word |=> (r_part_fsk == '0) && (r_part_tone == '0))
        else $error("partial words not cleared after word completion");

    // An error result always closes its request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> r_out_last)
        else $error("length error result without last");

endmodule

`default_nettype wire

/* design/fptp_ctrl.sv */
// Controller of the packer: sequences multiply, carry add, count, check, the per-sample loop, flush and error.
// Depends on fptp_pkg.
`default_nettype none

module fptp_ctrl
    import fptp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    input  wire        i_req_opcode,
    input  t_dp_status i_st,
    output logic       o_req_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_req_opcode == OP_FLUSH) ? S_FLUSH : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CNT;
            end
            S_CNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                priority if (i_st.samples_zero) begin
                    n_state = S_IDLE;
                end else if (i_st.overflow) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.arm = 1'b1;
                    n_state   = S_RUN;
                end
            end
            S_ERR: begin
                if (i_st.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_st.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RUN: begin
                // A sample that completes a word waits for the result register.
                if (i_st.out_free || !i_st.word_at_step) begin
                    o_cmd.step = 1'b1;
                    if (i_st.remain_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // At most one source of results is active in a cycle.
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.step, o_cmd.emit_flush, o_cmd.emit_err}))
        else $error("more than one result source active");

    // The final sample of a pulse returns the controller to idle.
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && o_cmd.step && i_st.remain_one) |=> (r_state == S_IDLE))
        else $error("sample loop did not finish");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

endmodule

`default_nettype wire

/* design/fsk_pulse_tone_packer_top.sv */
// Pulse request: multiply, carry add, count and length check, then one sample per cycle (up to 2048)
// unless a completed word waits; the phase accumulator steps once per sample. A flush waits for a free
// result register; a zero-sample pulse ends after the check. Word results come out of a registered
// result stage in the cycle after the sample that completes them; a full stage stalls the loop.
// Reset (i_rst_n, synchronous, active low) clears carry, phase, sample total, partial words
// and restores the register defaults.
// Top level of the FSK pulse and tone packer; depends on fptp_pkg, the channel interfaces,
// fptp_regs, fptp_dp and fptp_ctrl.
`default_nettype none

module fsk_pulse_tone_packer_top
    import fptp_pkg::*;
#(
    parameter int DURATION_BITS = 12
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    fptp_req_if.sink          i_req,
    fptp_rsp_if.source        o_rsp,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [SPU_W-1:0] spu;
    logic [INC_W-1:0] mark_inc;
    logic [INC_W-1:0] space_inc;
    t_dp_cmd          cmd;
    t_dp_status       st;
    logic             req_ready;

    // Configuration registers.
    fptp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_spu       (spu),
        .o_mark_inc  (mark_inc),
        .o_space_inc (space_inc)
    );

    // Sequencing.
    fptp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (i_req.opcode),
        .i_st         (st),
        .o_req_ready  (req_ready),
        .o_cmd        (cmd)
    );

    assign i_req.ready = req_ready;

    // Arithmetic, packing and result register.
    fptp_dp #(
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_pulse_polarity (i_req.pulse_polarity),
        .i_duration_units (i_req.duration_units),
        .i_spu            (spu),
        .i_mark_inc       (mark_inc),
        .i_space_inc      (space_inc),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_fsk_word       (o_rsp.fsk_word),
        .o_tone_word      (o_rsp.tone_word),
        .o_word_index     (o_rsp.word_index),
        .o_bit_count      (o_rsp.bit_count),
        .o_length_error   (o_rsp.length_error),
        .o_last           (o_rsp.last)
    );

endmodule

`default_nettype wire
